### rtl/core/tcch_pkg.sv
// Package for the tilt-compensated compass heading pipeline.
// Holds register codes, reset values, datapath widths and the arctangent table.
// No dependencies.
package tcch_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HARD_IRON_X     = 3'd0,
    REG_HARD_IRON_Y     = 3'd1,
    REG_HARD_IRON_Z     = 3'd2,
    REG_SOFT_IRON_DIAG  = 3'd3,
    REG_SOFT_IRON_OFF   = 3'd4,
    REG_DECLINATION     = 3'd5
  } cfg_reg_e;

  localparam logic signed [19:0] HARD_IRON_X_RST = -20'sd2739;
  localparam logic signed [19:0] HARD_IRON_Y_RST = -20'sd922;
  localparam logic signed [19:0] HARD_IRON_Z_RST = 20'sd1784;
  localparam logic [47:0]        SOFT_DIAG_RST   = 48'd70090642899042;
  localparam logic [47:0]        SOFT_OFF_RST    = 48'd281406266867712;
  localparam logic signed [15:0] DECLINATION_RST = 16'sd1024;

  localparam int unsigned CORDIC_ITER_DEF = 16;
  localparam int unsigned ATAN_STEPS      = 24;
  localparam int unsigned SQRT_STEPS      = 16;

  localparam int unsigned CX_W  = 34;  // CORDIC x/y width
  localparam int unsigned ANG_W = 32;  // angle, degrees Q20

  localparam logic signed [ANG_W-1:0] DEG360_Q20 = 32'sd377487360;
  localparam logic signed [ANG_W-1:0] DEG180_Q20 = 32'sd188743680;
  localparam int unsigned FULL_Q7 = 46080;

  typedef logic [1:0][31:0] sqrt_pair_t;

  typedef struct packed {
    logic valid;
    logic zero_acc;
    logic zero_xy;
  } tag_t;

  // arctan(2^-i) in degrees, Q20, rounded
  function automatic logic [25:0] atan_q20(input int unsigned idx);
    logic [25:0] v;
    unique case (idx)
      0:  v = 26'd47185920;
      1:  v = 26'd27855475;
      2:  v = 26'd14718068;
      3:  v = 26'd7471121;
      4:  v = 26'd3750058;
      5:  v = 26'd1876857;
      6:  v = 26'd938658;
      7:  v = 26'd469357;
      8:  v = 26'd234682;
      9:  v = 26'd117342;
      10: v = 26'd58671;
      11: v = 26'd29335;
      12: v = 26'd14668;
      13: v = 26'd7334;
      14: v = 26'd3667;
      15: v = 26'd1833;
      16: v = 26'd917;
      17: v = 26'd458;
      18: v = 26'd229;
      19: v = 26'd115;
      20: v = 26'd57;
      21: v = 26'd29;
      22: v = 26'd14;
      23: v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] lead_one17(input logic [16:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [5:0] lead_one64(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

### rtl/core/tcch_sqrt_cell.sv
// One digit step of the integer square root chain, two lanes side by side.
// Depends on tcch_pkg.
module tcch_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tcch_pkg::sqrt_pair_t rem_i,
  input  tcch_pkg::sqrt_pair_t root_i,
  output logic                 valid_o,
  output tcch_pkg::sqrt_pair_t rem_o,
  output tcch_pkg::sqrt_pair_t root_o
);

  localparam logic [31:0] BIT = 32'd1 << (30 - 2 * STEP);

  tcch_pkg::sqrt_pair_t rem_d, root_d, rem_q, root_q;
  logic                 valid_q;
  logic [32:0]          trial;

  always_comb begin
    rem_d  = rem_i;
    root_d = root_i;
    trial  = '0;
    for (int l = 0; l < 2; l++) begin
      trial = {1'b0, root_i[l]} + {1'b0, BIT};
      if ({1'b0, rem_i[l]} >= trial) begin
        rem_d[l]  = rem_i[l] - trial[31:0];
        root_d[l] = (root_i[l] >> 1) + BIT;
      end else begin
        root_d[l] = root_i[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

### rtl/core/tcch_cordic_cell.sv
// One vectoring micro-rotation of the CORDIC chain, angle kept in degrees Q20.
// Depends on tcch_pkg.
module tcch_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tcch_pkg::tag_t                          tag_i,
  input  logic signed [tcch_pkg::CX_W-1:0]        x_i,
  input  logic signed [tcch_pkg::CX_W-1:0]        y_i,
  input  logic signed [tcch_pkg::ANG_W-1:0]       ang_i,
  output tcch_pkg::tag_t                          tag_o,
  output logic signed [tcch_pkg::CX_W-1:0]        x_o,
  output logic signed [tcch_pkg::CX_W-1:0]        y_o,
  output logic signed [tcch_pkg::ANG_W-1:0]       ang_o
);

  localparam logic signed [tcch_pkg::ANG_W-1:0] ATAN =
    $signed({6'b0, tcch_pkg::atan_q20(STEP)});

  logic signed [tcch_pkg::CX_W-1:0]  dx, dy, x_d, y_d, x_q, y_q;
  logic signed [tcch_pkg::ANG_W-1:0] ang_d, ang_q;
  tcch_pkg::tag_t                    tag_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!y_i[tcch_pkg::CX_W-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + ATAN;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
  end

  assign tag_o = tag_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

### rtl/core/tilt_compensated_compass_heading.sv
// Tilt-compensated compass heading, fully pipelined.
// Throughput: one transaction per cycle; busy_o stays low and results cannot be stalled.
// The depth is set by the 16-cell square root chain and the CORDIC cell chain.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
// Depends on tcch_pkg, tcch_sqrt_cell and tcch_cordic_cell.
module tilt_compensated_compass_heading #(
  parameter int unsigned CORDIC_ITERATIONS = tcch_pkg::CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] mag_x_i,
  input  logic signed [15:0] mag_y_i,
  input  logic signed [15:0] mag_z_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [15:0]        heading_o,
  output logic               status_o
);

  localparam int unsigned SQ = tcch_pkg::SQRT_STEPS;
  localparam int unsigned LAT_CYCLES = 29 + CORDIC_ITERATIONS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [19:0] hi_x_q, hi_y_q, hi_z_q;
  logic [47:0]        si_diag_q, si_off_q;
  logic signed [15:0] decl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_x_q    <= tcch_pkg::HARD_IRON_X_RST;
      hi_y_q    <= tcch_pkg::HARD_IRON_Y_RST;
      hi_z_q    <= tcch_pkg::HARD_IRON_Z_RST;
      si_diag_q <= tcch_pkg::SOFT_DIAG_RST;
      si_off_q  <= tcch_pkg::SOFT_OFF_RST;
      decl_q    <= tcch_pkg::DECLINATION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcch_pkg::REG_HARD_IRON_X:    hi_x_q    <= $signed(cfg_wdata_i[19:0]);
        tcch_pkg::REG_HARD_IRON_Y:    hi_y_q    <= $signed(cfg_wdata_i[19:0]);
        tcch_pkg::REG_HARD_IRON_Z:    hi_z_q    <= $signed(cfg_wdata_i[19:0]);
        tcch_pkg::REG_SOFT_IRON_DIAG: si_diag_q <= cfg_wdata_i;
        tcch_pkg::REG_SOFT_IRON_OFF:  si_off_q  <= cfg_wdata_i;
        tcch_pkg::REG_DECLINATION:    decl_q    <= $signed(cfg_wdata_i[15:0]);
        default: ;
      endcase
    end
  end

  // No back-pressure anywhere: a transaction enters every cycle start_i is high.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid chain for the front and back stages (cells carry their own)
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic p1v_q, p2v_q, p3v_q, p4v_q, p5v_q, p6v_q;
  logic f1v_q, f2v_q, done_q;
  logic sq_valid [SQ+1];
  tcch_pkg::tag_t cr_tag [CORDIC_ITERATIONS+1];

  // ---------------------------------------------------------------------------
  // S1: hard-iron offset (4 fraction bits) and accel axis remap
  // ---------------------------------------------------------------------------
  logic signed [20:0] h1_d [3];
  logic signed [16:0] a1_d [3];
  logic signed [20:0] h1_q [3];
  logic signed [16:0] a1_q [3];
  logic               z1_q;

  assign h1_d[0] = 21'($signed({mag_x_i, 4'b0000})) - 21'(hi_x_q);
  assign h1_d[1] = 21'($signed({mag_y_i, 4'b0000})) - 21'(hi_y_q);
  assign h1_d[2] = 21'($signed({mag_z_i, 4'b0000})) - 21'(hi_z_q);
  assign a1_d[0] = 17'sd0 - 17'(accel_x_i);
  assign a1_d[1] = 17'sd0 - 17'(accel_y_i);
  assign a1_d[2] = 17'(accel_z_i);

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
    a1_q <= a1_d;
    z1_q <= (accel_x_i == 16'sd0) && (accel_y_i == 16'sd0) && (accel_z_i == 16'sd0);
  end

  // ---------------------------------------------------------------------------
  // S2: soft-iron products; accel normalized so its largest axis is >= 2^14
  // ---------------------------------------------------------------------------
  logic signed [15:0] cxx, cyy, czz, cxy, cxz, cyz;
  logic signed [36:0] p2_d [9];
  logic signed [36:0] p2_q [9];
  logic [16:0]        aabs [3];
  logic [16:0]        aor;
  logic [4:0]         alead;
  logic [3:0]         ashift;
  logic signed [16:0] a2_d [3];
  logic signed [16:0] a2_q [3];
  logic               z2_q;

  assign cxx = $signed(si_diag_q[15:0]);
  assign cyy = $signed(si_diag_q[31:16]);
  assign czz = $signed(si_diag_q[47:32]);
  assign cxy = $signed(si_off_q[15:0]);
  assign cxz = $signed(si_off_q[31:16]);
  assign cyz = $signed(si_off_q[47:32]);

  assign p2_d[0] = cxx * h1_q[0];
  assign p2_d[1] = cxy * h1_q[1];
  assign p2_d[2] = cxz * h1_q[2];
  assign p2_d[3] = cxy * h1_q[0];
  assign p2_d[4] = cyy * h1_q[1];
  assign p2_d[5] = cyz * h1_q[2];
  assign p2_d[6] = cxz * h1_q[0];
  assign p2_d[7] = cyz * h1_q[1];
  assign p2_d[8] = czz * h1_q[2];

  // OR of magnitudes has the same leading one as their maximum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aabs[i] = a1_q[i][16] ? 17'(17'sd0 - a1_q[i]) : 17'(a1_q[i]);
    end
    aor    = aabs[0] | aabs[1] | aabs[2];
    alead  = tcch_pkg::lead_one17(aor);
    ashift = (alead >= 5'd14) ? 4'd0 : 4'(5'd14 - alead);
    for (int i = 0; i < 3; i++) begin
      a2_d[i] = a1_q[i] <<< ashift;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q <= p2_d;
    a2_q <= a2_d;
    z2_q <= z1_q;
  end

  // ---------------------------------------------------------------------------
  // S3: matrix row sums, floor >> 12, mag remap; accel squares
  // ---------------------------------------------------------------------------
  logic signed [38:0] rsum [3];
  logic signed [27:0] m3_d [3];
  logic signed [33:0] sq3_d [3];
  logic signed [27:0] m3_q [3];
  logic signed [16:0] a3_q [3];
  logic [31:0]        sq3_q [3];
  logic               z3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i]  = 39'(p2_q[3*i]) + 39'(p2_q[3*i+1]) + 39'(p2_q[3*i+2]);
      sq3_d[i] = a2_q[i] * a2_q[i];
    end
    m3_d[0] = 28'sd0 - 28'($signed(rsum[0][38:12]));
    m3_d[1] = 28'($signed(rsum[1][38:12]));
    m3_d[2] = 28'sd0 - 28'($signed(rsum[2][38:12]));
  end

  always_ff @(posedge clk_i) begin
    m3_q <= m3_d;
    a3_q <= a2_q;
    for (int i = 0; i < 3; i++) begin
      sq3_q[i] <= sq3_d[i][31:0];
    end
    z3_q <= z2_q;
  end

  // ---------------------------------------------------------------------------
  // S4: radicands for r (y,z plane) and n (full vector)
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [27:0] mx;
    logic [27:0] my;
    logic [27:0] mz;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [16:0] az;
    logic        zero_acc;
  } side_t;

  side_t                side_q [SQ+1];
  tcch_pkg::sqrt_pair_t sq_rem [SQ+1];
  tcch_pkg::sqrt_pair_t sq_root [SQ+1];
  logic [31:0]          rad_r;

  assign rad_r = sq3_q[1] + sq3_q[2];

  always_ff @(posedge clk_i) begin
    sq_rem[0][0]  <= rad_r;
    sq_rem[0][1]  <= rad_r + sq3_q[0];
    sq_root[0]    <= '0;
    side_q[0]     <= '{mx: m3_q[0], my: m3_q[1], mz: m3_q[2],
                       ax: a3_q[0], ay: a3_q[1], az: a3_q[2], zero_acc: z3_q};
  end

  // Square root chain, side data follows in lock step
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    tcch_sqrt_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .valid_o (sq_valid[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1])
    );
    always_ff @(posedge clk_i) begin
      side_q[g+1] <= side_q[g];
    end
  end

  assign sq_valid[0] = v4_q;

  // ---------------------------------------------------------------------------
  // P1..P3: tilt compensation products, X and Y scaled by n*r (or n)
  // ---------------------------------------------------------------------------
  side_t              sd;
  logic signed [16:0] r_s, n_s;
  logic signed [27:0] mx, my, mz;
  logic signed [16:0] ax, ay, az;
  logic signed [44:0] t1_d, t2_d, t3_d, t4_d, t5_d, t6_d;
  logic signed [44:0] t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;
  logic signed [16:0] r1_q, n1_q, ax1_q;
  logic               r0_1_q, za1_q;

  assign sd  = side_q[SQ];
  assign r_s = $signed({1'b0, sq_root[SQ][0][15:0]});
  assign n_s = $signed({1'b0, sq_root[SQ][1][15:0]});
  assign mx  = $signed(sd.mx);
  assign my  = $signed(sd.my);
  assign mz  = $signed(sd.mz);
  assign ax  = $signed(sd.ax);
  assign ay  = $signed(sd.ay);
  assign az  = $signed(sd.az);

  assign t1_d = mx * r_s;
  assign t2_d = mz * ax;
  assign t3_d = mx * ay;
  assign t4_d = my * az;
  assign t5_d = mz * ay;
  assign t6_d = my * n_s;

  always_ff @(posedge clk_i) begin
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    t3_q   <= t3_d;
    t4_q   <= t4_d;
    t5_q   <= t5_d;
    t6_q   <= t6_d;
    r1_q   <= r_s;
    n1_q   <= n_s;
    ax1_q  <= ax;
    r0_1_q <= (sq_root[SQ][0] == 32'd0);
    za1_q  <= sd.zero_acc;
  end

  logic signed [45:0] d2_d, d2_q;
  logic signed [61:0] u1_d, u2_d, u3_d, u1_q, u2_q, u3_q;
  logic signed [44:0] t2_2_q, t6_2_q;
  logic signed [16:0] r2_q;
  logic               r0_2_q, za2_q;

  assign d2_d = 46'(t1_q) - 46'(t2_q);
  assign u1_d = t3_q * ax1_q;
  assign u2_d = t4_q * n1_q;
  assign u3_d = t5_q * r1_q;

  always_ff @(posedge clk_i) begin
    d2_q   <= d2_d;
    u1_q   <= u1_d;
    u2_q   <= u2_d;
    u3_q   <= u3_d;
    t2_2_q <= t2_q;
    t6_2_q <= t6_q;
    r2_q   <= r1_q;
    r0_2_q <= r0_1_q;
    za2_q  <= za1_q;
  end

  logic signed [62:0] xr;
  logic signed [63:0] x3_d, y3_d, x3_q, y3_q;
  logic               za3_q;

  assign xr   = d2_q * r2_q;
  // Accel along x only: r is zero and the n*r scaling drops to n
  assign x3_d = r0_2_q ? 64'sd0 - 64'(t2_2_q) : 64'(xr);
  assign y3_d = r0_2_q ? 64'(t6_2_q) : 64'(u2_q) - 64'(u1_q) - 64'(u3_q);

  always_ff @(posedge clk_i) begin
    x3_q  <= x3_d;
    y3_q  <= y3_d;
    za3_q <= za2_q;
  end

  // ---------------------------------------------------------------------------
  // P4..P6: scale X,Y together so max(|X|,|Y|) lands in [2^29, 2^30)
  // ---------------------------------------------------------------------------
  logic [63:0]        or4_d, or4_q;
  logic signed [63:0] x4_q, y4_q;
  logic               za4_q;

  assign or4_d = (x3_q[63] ? 64'(64'sd0 - x3_q) : 64'(x3_q)) |
                 (y3_q[63] ? 64'(64'sd0 - y3_q) : 64'(y3_q));

  always_ff @(posedge clk_i) begin
    or4_q <= or4_d;
    x4_q  <= x3_q;
    y4_q  <= y3_q;
    za4_q <= za3_q;
  end

  logic [5:0]         lead5_q;
  logic signed [63:0] x5_q, y5_q;
  logic               za5_q, zxy5_q;

  always_ff @(posedge clk_i) begin
    lead5_q <= tcch_pkg::lead_one64(or4_q);
    zxy5_q  <= (or4_q == 64'd0);
    x5_q    <= x4_q;
    y5_q    <= y4_q;
    za5_q   <= za4_q;
  end

  logic signed [tcch_pkg::CX_W-1:0]  xs, ys;
  logic signed [tcch_pkg::CX_W-1:0]  cr_x [CORDIC_ITERATIONS+1];
  logic signed [tcch_pkg::CX_W-1:0]  cr_y [CORDIC_ITERATIONS+1];
  logic signed [tcch_pkg::ANG_W-1:0] cr_a [CORDIC_ITERATIONS+1];

  always_comb begin
    if (lead5_q > 6'd29) begin
      xs = tcch_pkg::CX_W'(x5_q >>> (lead5_q - 6'd29));
      ys = tcch_pkg::CX_W'(y5_q >>> (lead5_q - 6'd29));
    end else begin
      xs = tcch_pkg::CX_W'(x5_q <<< (6'd29 - lead5_q));
      ys = tcch_pkg::CX_W'(y5_q <<< (6'd29 - lead5_q));
    end
  end

  // Left half-plane: turn by 180 degrees before the micro-rotations
  always_ff @(posedge clk_i) begin
    if (xs[tcch_pkg::CX_W-1]) begin
      cr_x[0] <= -xs;
      cr_y[0] <= -ys;
      cr_a[0] <= tcch_pkg::DEG180_Q20;
    end else begin
      cr_x[0] <= xs;
      cr_y[0] <= ys;
      cr_a[0] <= '0;
    end
  end

  logic za6_q, zxy6_q;
  always_ff @(posedge clk_i) begin
    za6_q  <= za5_q;
    zxy6_q <= zxy5_q;
  end

  assign cr_tag[0] = '{valid: p6v_q, zero_acc: za6_q, zero_xy: zxy6_q};

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
    tcch_cordic_cell #(.STEP(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (cr_tag[g]),
      .x_i    (cr_x[g]),
      .y_i    (cr_y[g]),
      .ang_i  (cr_a[g]),
      .tag_o  (cr_tag[g+1]),
      .x_o    (cr_x[g+1]),
      .y_o    (cr_y[g+1]),
      .ang_o  (cr_a[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // F1..F3: wrap to [0,360), round to Q7, add declination, wrap again
  // ---------------------------------------------------------------------------
  tcch_pkg::tag_t                    ct;
  logic signed [tcch_pkg::ANG_W-1:0] ang, a1, a2;
  logic [28:0]                       f1_q;
  logic                              za_f1_q, za_f2_q;

  assign ct  = cr_tag[CORDIC_ITERATIONS];
  assign ang = cr_a[CORDIC_ITERATIONS];

  always_comb begin
    a1 = ang[tcch_pkg::ANG_W-1] ? ang + tcch_pkg::DEG360_Q20 : ang;
    a2 = (a1 >= tcch_pkg::DEG360_Q20) ? a1 - tcch_pkg::DEG360_Q20 : a1;
    // Zero horizontal field: angle taken as zero
    if (ct.zero_xy) a2 = '0;
  end

  always_ff @(posedge clk_i) begin
    f1_q    <= a2[28:0];
    za_f1_q <= ct.zero_acc;
  end

  logic [29:0]        rnd;
  logic [15:0]        h_q7;
  logic signed [17:0] f2_d, f2_q;

  assign rnd  = {1'b0, f1_q} + 30'd4096;
  // 360.0 after rounding wraps to zero
  assign h_q7 = (rnd[29:13] == 17'(tcch_pkg::FULL_Q7)) ? 16'd0 : rnd[28:13];
  assign f2_d = $signed({2'b00, h_q7}) + 18'(decl_q);

  always_ff @(posedge clk_i) begin
    f2_q    <= f2_d;
    za_f2_q <= za_f1_q;
  end

  logic signed [17:0] f3;
  logic [15:0]        heading_q;
  logic               status_q;

  always_comb begin
    if (f2_q < 18'sd0) begin
      f3 = f2_q + 18'(tcch_pkg::FULL_Q7);
    end else if (f2_q >= 18'(tcch_pkg::FULL_Q7)) begin
      f3 = f2_q - 18'(tcch_pkg::FULL_Q7);
    end else begin
      f3 = f2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q <= za_f2_q ? 16'd0 : f3[15:0];
    status_q  <= za_f2_q;
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      p1v_q  <= 1'b0;
      p2v_q  <= 1'b0;
      p3v_q  <= 1'b0;
      p4v_q  <= 1'b0;
      p5v_q  <= 1'b0;
      p6v_q  <= 1'b0;
      f1v_q  <= 1'b0;
      f2v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      p1v_q  <= sq_valid[SQ];
      p2v_q  <= p1v_q;
      p3v_q  <= p2v_q;
      p4v_q  <= p3v_q;
      p5v_q  <= p4v_q;
      p6v_q  <= p5v_q;
      f1v_q  <= ct.valid;
      f2v_q  <= f1v_q;
      done_q <= f2v_q;
    end
  end

  assign done_o    = done_q;
  assign heading_o = heading_q;
  assign status_o  = status_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT_CYCLES done_o)
    else $error("result strobe missing after fixed latency");

  a_zero_accel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && accel_x_i == 16'sd0 && accel_y_i == 16'sd0 && accel_z_i == 16'sd0)
      |-> ##LAT_CYCLES (done_o && status_o))
    else $error("zero accel vector did not flag status");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_o < 16'(tcch_pkg::FULL_Q7)))
    else $error("heading out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (heading_o == 16'd0))
    else $error("heading not cleared on error status");
`endif

endmodule
